// ----- sv/c2p_pkg.sv -----
// Package for the Cartesian-to-polar range/azimuth block.
// Holds the CORDIC angle table, gain and rounding constants and the
// pipeline control type. No dependencies.
`default_nettype none

package c2p_pkg;

  // Guard fraction bits added to the coordinates inside the CORDIC.
  localparam int GUARD_BITS = 8;

  // Result field widths.
  localparam int RANGE_W = 25;
  localparam int AZ_W    = 16;

  // Largest range value; larger results saturate here.
  localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};

  // Reciprocal of the CORDIC limit gain, as a fraction of 2^32.
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  // Half a turn in the 32-bit angle format.
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Half an LSB of the 16-bit azimuth, in the 32-bit angle format.
  localparam logic [31:0] AZ_ROUND = 32'h0000_8000;

  // atan(2^-i) in units of 2^-32 of a full turn, rounded to nearest.
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic valid;  // stage holds a transaction
    logic zero;   // the two points coincide
  } ctl_t;

endpackage

`default_nettype wire

// ----- sv/c2p_in_if.sv -----
// Input channel interface: a point pair with valid/ready handshake.
// Depends on nothing; the coordinate width is an interface parameter.
`default_nettype none

interface c2p_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] own_x;
  logic signed [COORD_WIDTH-1:0] own_y;
  logic signed [COORD_WIDTH-1:0] ref_x;
  logic signed [COORD_WIDTH-1:0] ref_y;

  modport source (output valid, own_x, own_y, ref_x, ref_y, input ready);
  modport sink   (input valid, own_x, own_y, ref_x, ref_y, output ready);
endinterface

`default_nettype wire

// ----- sv/c2p_out_if.sv -----
// Result channel interface: range and azimuth with valid/ready handshake.
// Field widths come from c2p_pkg.
`default_nettype none

interface c2p_out_if;
  logic                         valid;
  logic                         ready;
  logic [c2p_pkg::RANGE_W-1:0]  range_out;
  logic [c2p_pkg::AZ_W-1:0]     azimuth_out;

  modport source (output valid, range_out, azimuth_out, input ready);
  modport sink   (input valid, range_out, azimuth_out, output ready);
endinterface

`default_nettype wire

// ----- sv/c2p_front.sv -----
// Front stage: difference of the two points, guard bits and half-plane
// pre-rotation so that x is non-negative. Uses c2p_pkg.
`default_nettype none

module c2p_front #(
  parameter int COORD_WIDTH = 24,
  parameter int XW          = 35
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire signed [COORD_WIDTH-1:0] own_x,
  input  wire signed [COORD_WIDTH-1:0] own_y,
  input  wire signed [COORD_WIDTH-1:0] ref_x,
  input  wire signed [COORD_WIDTH-1:0] ref_y,
  output c2p_pkg::ctl_t                ctl_r,
  output logic signed [XW-1:0]         x_r,
  output logic signed [XW-1:0]         y_r,
  output logic [31:0]                  z_r
);

  localparam int EXT = XW - COORD_WIDTH - 1 - c2p_pkg::GUARD_BITS;

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic signed [XW-1:0]        xg;
  logic signed [XW-1:0]        yg;
  c2p_pkg::ctl_t               ctl_nxt;
  logic signed [XW-1:0]        x_nxt;
  logic signed [XW-1:0]        y_nxt;
  logic [31:0]                 z_nxt;

  // Exact difference in one extra bit, then scale by the guard bits.
  always_comb begin
    dx = {own_x[COORD_WIDTH-1], own_x} - {ref_x[COORD_WIDTH-1], ref_x};
    dy = {own_y[COORD_WIDTH-1], own_y} - {ref_y[COORD_WIDTH-1], ref_y};
    xg = {{EXT{dx[COORD_WIDTH]}}, dx, {c2p_pkg::GUARD_BITS{1'b0}}};
    yg = {{EXT{dy[COORD_WIDTH]}}, dy, {c2p_pkg::GUARD_BITS{1'b0}}};
  end

  // Negative x: rotate by half a turn by negating both coordinates.
  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.zero  = (dx == '0) && (dy == '0);
    if (dx[COORD_WIDTH]) begin
      x_nxt = -xg;
      y_nxt = -yg;
      z_nxt = c2p_pkg::HALF_TURN;
    end else begin
      x_nxt = xg;
      y_nxt = yg;
      z_nxt = '0;
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/c2p_cell.sv -----
// One CORDIC vectoring micro-rotation with its output register.
// The shift amount and table angle are fixed by IDX. Uses c2p_pkg.
`default_nettype none

module c2p_cell #(
  parameter int XW  = 35,
  parameter int IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  c2p_pkg::ctl_t         ctl_in,
  input  wire signed [XW-1:0]   x_in,
  input  wire signed [XW-1:0]   y_in,
  input  wire [31:0]            z_in,
  output c2p_pkg::ctl_t         ctl_r,
  output logic signed [XW-1:0]  x_r,
  output logic signed [XW-1:0]  y_r,
  output logic [31:0]           z_r
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic [31:0]          z_nxt;

  // Arithmetic shifts floor; the sign of y picks the direction.
  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + c2p_pkg::ATAN_TURN[IDX];
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - c2p_pkg::ATAN_TURN[IDX];
    end
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/c2p_gain.sv -----
// Gain correction and output formatting: multiply by 1/K in two 32-bit
// partial products, then round, saturate and hold the result. Uses c2p_pkg.
`default_nettype none

module c2p_gain #(
  parameter int XW = 35
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  c2p_pkg::ctl_t                 ctl_in,
  input  wire signed [XW-1:0]           x_in,
  input  wire [31:0]                    z_in,
  output logic                          valid_r,
  output logic [c2p_pkg::RANGE_W-1:0]   range_r,
  output logic [c2p_pkg::AZ_W-1:0]      azimuth_r
);

  localparam int HIW  = (XW > 32) ? XW - 32 : 1;
  localparam int MAGW = 32 + HIW;
  localparam int PW   = HIW + 34;

  logic [XW-1:0]        mag;
  logic [MAGW-1:0]      mag_ext;
  logic [HIW+31:0]      hi_prod;
  logic [63:0]          lo_prod;
  c2p_pkg::ctl_t        ctl_m_r;
  logic [HIW+31:0]      hi_prod_r;
  logic [31:0]          lo_top_r;
  logic [31:0]          z_m_r;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        range_full;
  logic [31:0]          z_rnd;
  logic [c2p_pkg::RANGE_W-1:0] range_nxt;
  logic [c2p_pkg::AZ_W-1:0]    azimuth_nxt;

  // Partial products of the clamped magnitude and the inverse gain.
  always_comb begin
    mag     = x_in[XW-1] ? '0 : XW'(x_in);
    mag_ext = MAGW'(mag);
    hi_prod = (HIW+32)'(mag_ext[MAGW-1:32]) * (HIW+32)'(c2p_pkg::INV_GAIN_Q32);
    lo_prod = 64'(mag_ext[31:0]) * 64'(c2p_pkg::INV_GAIN_Q32);
  end

  // Product stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
    end else if (en) begin
      ctl_m_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_prod_r <= hi_prod;
      lo_top_r  <= lo_prod[63:32];
      z_m_r     <= z_in;
    end
  end

  // Sum, drop the guard bits rounding half up, saturate, round the angle.
  always_comb begin
    prod       = PW'(hi_prod_r) + PW'(lo_top_r);
    range_full = (prod + PW'(1 << (c2p_pkg::GUARD_BITS - 1))) >> c2p_pkg::GUARD_BITS;
    z_rnd      = z_m_r + c2p_pkg::AZ_ROUND;
    if (range_full > PW'(c2p_pkg::RANGE_MAX)) begin
      range_nxt = c2p_pkg::RANGE_MAX;
    end else begin
      range_nxt = range_full[c2p_pkg::RANGE_W-1:0];
    end
    if (ctl_m_r.zero) begin
      range_nxt   = '0;
      azimuth_nxt = '0;
    end else begin
      azimuth_nxt = z_rnd[31:32-c2p_pkg::AZ_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_m_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_r   <= range_nxt;
      azimuth_r <= azimuth_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cartesian_to_polar_range_azimuth_top.sv -----
// Top level of the Cartesian-to-polar range/azimuth block.
// Depends on c2p_pkg, c2p_in_if, c2p_out_if, c2p_front, c2p_cell, c2p_gain.
//
// The block takes a pair of points per transaction and returns the distance
// between them (1/16 m units) and the azimuth of the own point from the
// reference point as a 16-bit fraction of a full turn. It accepts one
// transaction every clock cycle unless the output stalls; each result
// passes through the front stage, one CORDIC cell per iteration, the
// product stage and the output register. The whole pipeline advances
// together: while the output register holds a result that has not been
// taken, in_ch.ready is low; it rises again in the cycle the result is taken.
`default_nettype none

module cartesian_to_polar_range_azimuth_top #(
  parameter int COORD_WIDTH = 24,
  parameter int ITERATIONS  = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  c2p_in_if.sink     in_ch,
  c2p_out_if.source  out_ch
);

  // Two bits of headroom cover the sqrt(2) and CORDIC gain growth.
  localparam int XW = COORD_WIDTH + 1 + c2p_pkg::GUARD_BITS + 2;

  logic                 advance;
  logic                 out_valid;
  c2p_pkg::ctl_t        ctl   [ITERATIONS+1];
  logic signed [XW-1:0] x_p   [ITERATIONS+1];
  logic signed [XW-1:0] y_p   [ITERATIONS+1];
  logic [31:0]          z_p   [ITERATIONS+1];

  // The pipeline moves whenever the output register is free or being read.
  assign advance      = !out_valid || out_ch.ready;
  assign in_ch.ready  = advance;
  assign out_ch.valid = out_valid;

  c2p_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_ch.valid),
    .own_x    (in_ch.own_x),
    .own_y    (in_ch.own_y),
    .ref_x    (in_ch.ref_x),
    .ref_y    (in_ch.ref_y),
    .ctl_r    (ctl[0]),
    .x_r      (x_p[0]),
    .y_r      (y_p[0]),
    .z_r      (z_p[0])
  );

  // Row of micro-rotation cells.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    c2p_cell #(
      .XW  (XW),
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .ctl_in (ctl[i]),
      .x_in   (x_p[i]),
      .y_in   (y_p[i]),
      .z_in   (z_p[i]),
      .ctl_r  (ctl[i+1]),
      .x_r    (x_p[i+1]),
      .y_r    (y_p[i+1]),
      .z_r    (z_p[i+1])
    );
  end

  c2p_gain #(
    .XW (XW)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .ctl_in    (ctl[ITERATIONS]),
    .x_in      (x_p[ITERATIONS]),
    .z_in      (z_p[ITERATIONS]),
    .valid_r   (out_valid),
    .range_r   (out_ch.range_out),
    .azimuth_r (out_ch.azimuth_out)
  );

  // A held result must stall the input side.
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while a result is stalled");

  // A zero range only comes from coincident points, whose azimuth is zero.
  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.range_out == '0) |-> (out_ch.azimuth_out == '0))
    else $error("zero range with nonzero azimuth");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
